// File: rtl/area_average_downscale_horizontal_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the horizontal area-average downscaler
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AREA_AVERAGE_DOWNSCALE_HORIZONTAL_ASSERT_SVH
`define AREA_AVERAGE_DOWNSCALE_HORIZONTAL_ASSERT_SVH

`ifndef SYNTH

// Property p must hold at every clock edge outside reset.
`define AADH_ASSERT_ALWAYS(lbl, clk, rst_n, p) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (p)) \
    else $error("assertion failed");

// Condition a implies b in the same cycle.
`define AADH_ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Condition a implies b in the next cycle.
`define AADH_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`else

`define AADH_ASSERT_ALWAYS(lbl, clk, rst_n, p)
`define AADH_ASSERT_IMPLIES(lbl, clk, rst_n, a, b)
`define AADH_ASSERT_NEXT(lbl, clk, rst_n, a, b)

`endif

`endif

// File: rtl/aadh_pkg.sv
// ----------------------------------------------------------------------------
// Horizontal area-average downscaler package
// Payload types, control structs, state encoding and register indexes.
// ----------------------------------------------------------------------------
package aadh_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int RATIO_W    = 12;
  localparam int TOTAL_W    = RATIO_W + 1;
  localparam int SUM_W      = 20;
  localparam int LANE_MAX   = 4;
  localparam int LANES_W    = 3;
  localparam int QUOT_W     = 8;
  localparam int DIV_CNT_W  = $clog2(QUOT_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_NUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_DEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LANES_USED = 2'd2;

  // Index of the first (most significant) quotient bit resolved.
  localparam logic [DIV_CNT_W-1:0] DIV_FIRST = DIV_CNT_W'(QUOT_W - 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] lane3;
    logic [SAMPLE_W-1:0] lane2;
    logic [SAMPLE_W-1:0] lane1;
    logic [SAMPLE_W-1:0] lane0;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out_lane3;
    logic [SAMPLE_W-1:0] out_lane2;
    logic [SAMPLE_W-1:0] out_lane1;
    logic [SAMPLE_W-1:0] out_lane0;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } aadh_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 accept;
    logic                 div_step;
    logic [DIV_CNT_W-1:0] div_idx;
    logic                 out_load;
  } aadh_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic span_done;
  } aadh_stat_t;

endpackage

// File: rtl/aadh_ctrl.sv
// ----------------------------------------------------------------------------
// Downscaler controller
// Sequences request acceptance, the bit-serial divide and the output load.
// ----------------------------------------------------------------------------
`include "area_average_downscale_horizontal_assert.svh"

module aadh_ctrl import aadh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  aadh_stat_t stat,
  output aadh_cmd_t  cmd
);

  aadh_state_t          state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;
  logic                 in_accept;

  // The output register can take a new request when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_accept = in_valid && !in_stall;

  // Next state and divide bit counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && stat.span_done) begin
          state_nxt = ST_DIV;
          cnt_nxt   = DIV_FIRST;
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_HOLD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    in_stall     = 1'b1;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.div_idx  = cnt_r;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_HOLD: begin
        cmd.out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Output valid is set on load and cleared when the request is taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `AADH_ASSERT_NEXT(a_span_starts_div, clk, rst_n, cmd.accept && stat.span_done, state_r == ST_DIV && cnt_r == DIV_FIRST)
  `AADH_ASSERT_NEXT(a_div_ends_in_hold, clk, rst_n, state_r == ST_DIV && cnt_r == '0, state_r == ST_HOLD)
  `AADH_ASSERT_IMPLIES(a_load_when_free, clk, rst_n, cmd.out_load, !(out_valid_r && out_stall))

endmodule

// File: rtl/aadh_dp.sv
// ----------------------------------------------------------------------------
// Downscaler datapath
// Configuration registers, per-lane span accumulators, restoring dividers
// and the output register.
// ----------------------------------------------------------------------------
`include "area_average_downscale_horizontal_assert.svh"

module aadh_dp import aadh_pkg::*; #(
  parameter int LANES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  aadh_cmd_t             cmd,
  output aadh_stat_t            stat,
  output out_item_t             out_data
);

  logic [RATIO_W-1:0]  ratio_num_r;
  logic [RATIO_W-1:0]  ratio_den_r;
  logic [LANES_W-1:0]  lanes_used_r;
  logic [RATIO_W-1:0]  span_fill_r;
  logic [SUM_W-1:0]    sums_r   [LANES];
  logic [SUM_W-1:0]    sums_nxt [LANES];
  logic [SUM_W-1:0]    sum_full [LANES];
  logic [SUM_W-1:0]    rem_r    [LANES];
  logic [QUOT_W-1:0]   quot_r   [LANES];
  logic [QUOT_W-1:0]   quot_ext [LANE_MAX];
  logic [SAMPLE_W-1:0] samples  [LANE_MAX];
  logic [SAMPLE_W-1:0] out_r    [LANE_MAX];
  logic [SAMPLE_W-1:0] out_nxt  [LANE_MAX];

  logic [RATIO_W-1:0]  den_eff;
  logic [RATIO_W-1:0]  num_raw;
  logic [RATIO_W-1:0]  num_eff;
  logic [TOTAL_W-1:0]  total;
  logic [RATIO_W-1:0]  take;
  logic [RATIO_W-1:0]  rest;
  logic [RATIO_W-1:0]  mul_factor;
  logic [RATIO_W-1:0]  fill_nxt;
  logic [SUM_W-1:0]    trial;
  logic                cfg_hit;

  // Zero ratios act as one; the numerator saturates at the denominator.
  assign den_eff = (ratio_den_r == '0) ? RATIO_W'(1) : ratio_den_r;
  assign num_raw = (ratio_num_r == '0) ? RATIO_W'(1) : ratio_num_r;
  assign num_eff = (num_raw > den_eff) ? den_eff : num_raw;

  // Span bookkeeping: does this pixel close the open span?
  assign total          = TOTAL_W'(span_fill_r) + TOTAL_W'(num_eff);
  assign stat.span_done = (total >= TOTAL_W'(den_eff));
  assign take           = den_eff - span_fill_r;
  assign rest           = RATIO_W'(total - TOTAL_W'(den_eff));
  assign mul_factor     = stat.span_done ? take : num_eff;
  assign fill_nxt       = stat.span_done ? rest : RATIO_W'(total);

  assign samples[0] = in_data.lane0;
  assign samples[1] = in_data.lane1;
  assign samples[2] = in_data.lane2;
  assign samples[3] = in_data.lane3;

  // Per-lane weighted accumulation and the sum that closes a span.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [SUM_W-1:0] prod_in;
    logic [SUM_W-1:0] prod_rest;
    assign prod_in     = SUM_W'(samples[g]) * SUM_W'(mul_factor);
    assign prod_rest   = SUM_W'(samples[g]) * SUM_W'(rest);
    assign sum_full[g] = sums_r[g] + prod_in;
    assign sums_nxt[g] = stat.span_done ? prod_rest : sum_full[g];
  end

  // A write to a listed register also restarts the span.
  always_comb begin
    case (cfg_index)
      REG_RATIO_NUM, REG_RATIO_DEN, REG_LANES_USED: cfg_hit = cfg_we;
      default:                                      cfg_hit = 1'b0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_num_r  <= RATIO_W'(1);
      ratio_den_r  <= RATIO_W'(1);
      lanes_used_r <= LANES_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATIO_NUM:  ratio_num_r  <= cfg_data[RATIO_W-1:0];
        REG_RATIO_DEN:  ratio_den_r  <= cfg_data[RATIO_W-1:0];
        REG_LANES_USED: lanes_used_r <= cfg_data[LANES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Span state: fill count and lane sums.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      span_fill_r <= '0;
      for (int i = 0; i < LANES; i++) begin
        sums_r[i] <= '0;
      end
    end else if (cmd.accept) begin
      span_fill_r <= fill_nxt;
      for (int i = 0; i < LANES; i++) begin
        sums_r[i] <= sums_nxt[i];
      end
    end
  end

  // Restoring divider, one quotient bit per step for all lanes at once.
  assign trial = SUM_W'(den_eff) << cmd.div_idx;

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (cmd.accept && stat.span_done) begin
        rem_r[i]  <= sum_full[i];
        quot_r[i] <= '0;
      end else if (cmd.div_step && (rem_r[i] >= trial)) begin
        rem_r[i]                <= rem_r[i] - trial;
        quot_r[i][cmd.div_idx] <= 1'b1;
      end
    end
  end

  // Lanes that are not built or not in use give zero.
  for (genvar g = 0; g < LANE_MAX; g++) begin : g_quot
    if (g < LANES) begin : g_live
      assign quot_ext[g] = quot_r[g];
    end else begin : g_zero
      assign quot_ext[g] = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < LANE_MAX; i++) begin
      out_nxt[i] = (LANES_W'(i) < lanes_used_r) ? quot_ext[i] : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      for (int i = 0; i < LANE_MAX; i++) begin
        out_r[i] <= out_nxt[i];
      end
    end
  end

  assign out_data.out_lane0 = out_r[0];
  assign out_data.out_lane1 = out_r[1];
  assign out_data.out_lane2 = out_r[2];
  assign out_data.out_lane3 = out_r[3];

  `AADH_ASSERT_ALWAYS(a_fill_below_den, clk, rst_n, span_fill_r < den_eff)
  `AADH_ASSERT_IMPLIES(a_rem_below_den, clk, rst_n, cmd.out_load, rem_r[0] < SUM_W'(den_eff))

endmodule

// File: rtl/area_average_downscale_horizontal.sv
// ----------------------------------------------------------------------------
// Horizontal area-average downscaler, top level
// Source pixels of up to four 8-bit lanes go in on the in_ channel; each
// closed span leaves as one averaged pixel on the out_ channel. Both channels
// use valid/stall: a request moves at a clock edge with valid high and stall
// low. The cfg_ port writes ratio_num (index 0), ratio_den (index 1) and
// lanes_used (index 2); any such write restarts the span. Write it only while
// the block is idle.
// A pixel that does not close a span leaves the block idle and ready for the
// next pixel. A pixel that closes a span is accepted, then the eight-step
// restoring divider resolves one quotient bit per cycle for all lanes, and
// the hold state then loads the output register once it is free; in_stall is
// high from acceptance until that load. The next pixel can be accepted while
// the result still waits in the output register; a stalled receiver only
// holds the block when a further result is ready to be loaded.
// Reset sets both ratios and lanes_used to 1 and clears the lane sums and the
// fill count.
// ----------------------------------------------------------------------------
module area_average_downscale_horizontal import aadh_pkg::*; #(
  parameter int LANES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  aadh_cmd_t  cmd;
  aadh_stat_t stat;

  // Controller: handshakes and divide sequencing.
  aadh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: accumulators, dividers and output register.
  aadh_dp #(
    .LANES (LANES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule
